### rtl/mpe_pkg.sv
// Package for multipoint_poly_eval_mod_n: sequencer states, action and register codes,
// default sizes and the modular add used by the shared multiply unit.
// No dependencies.
package mpe_pkg;

    localparam int MAX_COEFFS_DEF = 256;
    localparam int MAX_POINTS_DEF = 64;

    localparam logic [1:0] ACT_LOAD_COEF  = 2'd0;
    localparam logic [1:0] ACT_LOAD_POINT = 2'd1;
    localparam logic [1:0] ACT_START      = 2'd2;

    localparam logic [1:0] REG_MODULUS     = 2'd0;
    localparam logic [1:0] REG_COEF_COUNT  = 2'd1;
    localparam logic [1:0] REG_POINT_COUNT = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LD_COEF,
        ST_LD_POINT,
        ST_P_RD,
        ST_P_RED,
        ST_C_RD,
        ST_MUL,
        ST_C_RED,
        ST_ADD,
        ST_OUT
    } state_t;

    function automatic logic [63:0] add_mod(input logic [63:0] a, input logic [63:0] b,
                                            input logic [63:0] m);
        logic [64:0] s;
        logic [64:0] d;
        s = {1'b0, a} + {1'b0, b};
        d = s - {1'b0, m};
        if (m == 64'd0) begin
            add_mod = s[63:0];
        end else if (s >= {1'b0, m}) begin
            add_mod = d[63:0];
        end else begin
            add_mod = s[63:0];
        end
    endfunction

endpackage

### rtl/multipoint_poly_eval_mod_n.sv
// Top level of multipoint_poly_eval_mod_n: coefficient and point stores, Horner sequencer
// and one bit-serial modular multiply unit. Depends on mpe_pkg.
//
//  channel | ports                                   | transfer when
//  input   | s_action, s_operand_value               | s_valid && s_ready
//  result  | m_result_value, m_point_index, m_last_* | m_valid && m_ready
//  config  | cfg_wr_en, cfg_index, cfg_data          | cfg_wr_en
//
// A load is accepted, then 64 steps of the multiply unit reduce the operand. A start reads
// and reduces each point, then runs a multiply, a reduction and an add per coefficient;
// every multiply and reduction runs one bit per cycle through the single shared unit.
// Reset clears control state only; stores are undefined until written.
// The block stalls with s_ready low while busy and holds each result until taken.
module multipoint_poly_eval_mod_n #(
    parameter int MAX_COEFFS = mpe_pkg::MAX_COEFFS_DEF,
    parameter int MAX_POINTS = mpe_pkg::MAX_POINTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [63:0] s_operand_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_result_value,
    output logic [5:0]  m_point_index,
    output logic        m_last_result,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int CA = (MAX_COEFFS > 1) ? $clog2(MAX_COEFFS) : 1;
    localparam int CW = $clog2(MAX_COEFFS + 1);
    localparam int PA = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int PW = $clog2(MAX_POINTS + 1);
    localparam int NW = (CW > 9) ? CW : 9;
    localparam int QW = (PW > 7) ? PW : 7;

    mpe_pkg::state_t state_reg, state_next;

    logic [63:0] modulus_reg;
    logic [8:0]  coef_count_reg;
    logic [6:0]  point_count_reg;

    logic [63:0] coef_mem [MAX_COEFFS];
    logic [63:0] point_mem [MAX_POINTS];
    logic [63:0] cdata_reg, pdata_reg;

    logic [CW-1:0] cwi_reg;
    logic [PW-1:0] pwi_reg;
    logic [CW-1:0] k_reg;
    logic [PW-1:0] pi_reg;

    logic [63:0] r_reg, a_reg, b_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] acc_reg, x_reg, prod_reg;
    logic [63:0] r_step;
    logic        unit_done;

    logic [63:0] one_val;
    logic [CW-1:0] ncoef;
    logic [PW-1:0] npts;
    logic [NW-1:0] ncoef_w;
    logic [QW-1:0] npts_w;
    logic          s_xfer, m_xfer, is_last;
    logic [CW-1:0] k_dec;
    logic [CA-1:0] c_rd_addr;
    logic [PA-1:0] p_rd_addr;

    assign one_val   = (modulus_reg == 64'd1) ? 64'd0 : 64'd1;
    assign ncoef_w   = (NW'(coef_count_reg) > NW'(MAX_COEFFS)) ? NW'(MAX_COEFFS)
                                                              : NW'(coef_count_reg);
    assign npts_w    = (QW'(point_count_reg) > QW'(MAX_POINTS)) ? QW'(MAX_POINTS)
                                                               : QW'(point_count_reg);
    assign ncoef     = ncoef_w[CW-1:0];
    assign npts      = npts_w[PW-1:0];
    assign s_xfer    = s_valid && s_ready;
    assign m_xfer    = m_valid && m_ready;
    assign is_last   = (pi_reg + PW'(1)) == npts;
    assign k_dec     = k_reg - CW'(1);
    assign c_rd_addr = k_dec[CA-1:0];
    assign p_rd_addr = pi_reg[PA-1:0];
    assign unit_done = (cnt_reg == 6'd63);
    assign r_step    = mpe_pkg::add_mod(mpe_pkg::add_mod(r_reg, r_reg, modulus_reg),
                                        b_reg[63] ? a_reg : 64'd0, modulus_reg);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mpe_pkg::ST_IDLE: begin
                if (s_xfer) begin
                    case (s_action)
                        mpe_pkg::ACT_LOAD_COEF: begin
                            if (cwi_reg < CW'(MAX_COEFFS)) state_next = mpe_pkg::ST_LD_COEF;
                        end
                        mpe_pkg::ACT_LOAD_POINT: begin
                            if (pwi_reg < PW'(MAX_POINTS)) state_next = mpe_pkg::ST_LD_POINT;
                        end
                        mpe_pkg::ACT_START: begin
                            if (npts != PW'(0)) state_next = mpe_pkg::ST_P_RD;
                        end
                        default: state_next = mpe_pkg::ST_IDLE;
                    endcase
                end
            end
            mpe_pkg::ST_LD_COEF, mpe_pkg::ST_LD_POINT: begin
                if (unit_done) state_next = mpe_pkg::ST_IDLE;
            end
            mpe_pkg::ST_P_RD: state_next = mpe_pkg::ST_P_RED;
            mpe_pkg::ST_P_RED: begin
                if (unit_done) begin
                    state_next = (ncoef == CW'(0)) ? mpe_pkg::ST_OUT : mpe_pkg::ST_C_RD;
                end
            end
            mpe_pkg::ST_C_RD: state_next = mpe_pkg::ST_MUL;
            mpe_pkg::ST_MUL: begin
                if (unit_done) state_next = mpe_pkg::ST_C_RED;
            end
            mpe_pkg::ST_C_RED: begin
                if (unit_done) state_next = mpe_pkg::ST_ADD;
            end
            mpe_pkg::ST_ADD: begin
                state_next = (k_reg == CW'(0)) ? mpe_pkg::ST_OUT : mpe_pkg::ST_C_RD;
            end
            mpe_pkg::ST_OUT: begin
                if (m_xfer) state_next = is_last ? mpe_pkg::ST_IDLE : mpe_pkg::ST_P_RD;
            end
            default: state_next = mpe_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        m_valid = 1'b0;
        case (state_reg)
            mpe_pkg::ST_IDLE: s_ready = 1'b1;
            mpe_pkg::ST_OUT:  m_valid = 1'b1;
            default: begin
                s_ready = 1'b0;
                m_valid = 1'b0;
            end
        endcase
    end

    assign m_result_value = acc_reg;
    assign m_point_index  = 6'(pi_reg);
    assign m_last_result  = is_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= mpe_pkg::ST_IDLE;
            modulus_reg     <= 64'd2;
            coef_count_reg  <= 9'd0;
            point_count_reg <= 7'd0;
            cwi_reg         <= '0;
            pwi_reg         <= '0;
            pi_reg          <= '0;
            k_reg           <= '0;
            cnt_reg         <= 6'd0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    mpe_pkg::REG_MODULUS:     modulus_reg     <= cfg_data;
                    mpe_pkg::REG_COEF_COUNT:  coef_count_reg  <= cfg_data[8:0];
                    mpe_pkg::REG_POINT_COUNT: point_count_reg <= cfg_data[6:0];
                    default: ;
                endcase
            end
            case (state_reg)
                mpe_pkg::ST_IDLE: begin
                    cnt_reg <= 6'd0;
                    if (s_xfer && s_action == mpe_pkg::ACT_START) begin
                        cwi_reg <= '0;
                        pwi_reg <= '0;
                        pi_reg  <= '0;
                    end
                end
                mpe_pkg::ST_LD_COEF: begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (unit_done) cwi_reg <= cwi_reg + CW'(1);
                end
                mpe_pkg::ST_LD_POINT: begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (unit_done) pwi_reg <= pwi_reg + PW'(1);
                end
                mpe_pkg::ST_P_RED: begin
                    cnt_reg <= cnt_reg + 6'd1;
                    k_reg   <= ncoef;
                end
                mpe_pkg::ST_MUL, mpe_pkg::ST_C_RED: cnt_reg <= cnt_reg + 6'd1;
                mpe_pkg::ST_C_RD: begin
                    cnt_reg <= 6'd0;
                    k_reg   <= k_dec;
                end
                mpe_pkg::ST_OUT: begin
                    if (m_xfer && !is_last) pi_reg <= pi_reg + PW'(1);
                end
                default: cnt_reg <= 6'd0;
            endcase
        end
    end

    // shared unit: r = a * b mod m, one bit of b per cycle, msb first
    always_ff @(posedge aclk) begin
        case (state_reg)
            mpe_pkg::ST_IDLE: begin
                r_reg <= 64'd0;
                a_reg <= one_val;
                b_reg <= s_operand_value;
            end
            mpe_pkg::ST_P_RD: begin
                r_reg <= 64'd0;
                a_reg <= one_val;
                b_reg <= point_mem[p_rd_addr];
            end
            mpe_pkg::ST_C_RD: begin
                r_reg <= 64'd0;
                a_reg <= acc_reg;
                b_reg <= x_reg;
            end
            mpe_pkg::ST_LD_COEF, mpe_pkg::ST_LD_POINT, mpe_pkg::ST_P_RED,
            mpe_pkg::ST_MUL, mpe_pkg::ST_C_RED: begin
                if (state_reg == mpe_pkg::ST_MUL && unit_done) begin
                    r_reg <= 64'd0;
                    a_reg <= one_val;
                    b_reg <= cdata_reg;
                end else begin
                    r_reg <= r_step;
                    b_reg <= {b_reg[62:0], 1'b0};
                end
            end
            default: ;
        endcase
        if (state_reg == mpe_pkg::ST_P_RED && unit_done) begin
            x_reg   <= r_step;
            acc_reg <= 64'd0;
        end
        if (state_reg == mpe_pkg::ST_MUL && unit_done) prod_reg <= r_step;
        if (state_reg == mpe_pkg::ST_C_RED && unit_done) pdata_reg <= r_step;
        if (state_reg == mpe_pkg::ST_ADD) begin
            acc_reg <= mpe_pkg::add_mod(prod_reg, pdata_reg, modulus_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == mpe_pkg::ST_LD_COEF && unit_done) begin
            coef_mem[cwi_reg[CA-1:0]] <= r_step;
        end
        if (state_reg == mpe_pkg::ST_C_RD) cdata_reg <= coef_mem[c_rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (state_reg == mpe_pkg::ST_LD_POINT && unit_done) begin
            point_mem[pwi_reg[PA-1:0]] <= r_step;
        end
    end

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input and result both open");

    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (pi_reg < npts))
        else $error("result index beyond point count");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_result_value)))
        else $error("pending result changed");

    a_start_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && s_action == mpe_pkg::ACT_START) |=> (cwi_reg == '0 && pwi_reg == '0))
        else $error("start did not clear write indices");

endmodule

### dv/mpe_checker.sv
// Result checker for multipoint_poly_eval_mod_n: watches the input, result and config ports,
// predicts each point value by Horner's rule and compares in order. Depends on mpe_pkg.
module mpe_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [63:0] s_operand_value,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [63:0] m_result_value,
    input  logic [5:0]  m_point_index,
    input  logic        m_last_result,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    output int          fail_count,
    output int          pending_count
);

    typedef struct packed {
        logic [63:0] value;
        logic [5:0]  index;
        logic        last;
    } point_value_t;

    point_value_t pending_values[$];

    logic [63:0] modulus;
    logic [8:0]  coef_count;
    logic [6:0]  point_count;
    logic [63:0] coefs[mpe_pkg::MAX_COEFFS_DEF];
    logic [63:0] points[mpe_pkg::MAX_POINTS_DEF];
    int          coef_wr;
    int          point_wr;

    function automatic logic [63:0] mod_reduce(input logic [63:0] v);
        return (modulus == 64'd0) ? v : v % modulus;
    endfunction

    function automatic logic [63:0] horner_value(input logic [63:0] x, input int n);
        logic [127:0] acc;
        logic [127:0] xr;
        logic [127:0] t;
        acc = '0;
        xr  = {64'd0, mod_reduce(x)};
        for (int k = n - 1; k >= 0; k--) begin
            t = acc * xr + {64'd0, mod_reduce(coefs[k])};
            acc = (modulus == 64'd0) ? {64'd0, t[63:0]} : t % {64'd0, modulus};
        end
        return acc[63:0];
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] mismatch on %s: got 0x%h, want 0x%h", $time, field, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        int nc;
        int np;
        point_value_t want;
        if (!aresetn) begin
            modulus     = 64'd2;
            coef_count  = '0;
            point_count = '0;
            coef_wr     = 0;
            point_wr    = 0;
            pending_values.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    mpe_pkg::REG_MODULUS:     modulus = cfg_data;
                    mpe_pkg::REG_COEF_COUNT:  coef_count = cfg_data[8:0];
                    mpe_pkg::REG_POINT_COUNT: point_count = cfg_data[6:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                case (s_action)
                    mpe_pkg::ACT_LOAD_COEF: begin
                        if (coef_wr < mpe_pkg::MAX_COEFFS_DEF) begin
                            coefs[coef_wr] = mod_reduce(s_operand_value);
                            coef_wr++;
                        end
                    end
                    mpe_pkg::ACT_LOAD_POINT: begin
                        if (point_wr < mpe_pkg::MAX_POINTS_DEF) begin
                            points[point_wr] = mod_reduce(s_operand_value);
                            point_wr++;
                        end
                    end
                    mpe_pkg::ACT_START: begin
                        coef_wr  = 0;
                        point_wr = 0;
                        nc = (coef_count > mpe_pkg::MAX_COEFFS_DEF) ? mpe_pkg::MAX_COEFFS_DEF
                                                                    : coef_count;
                        np = (point_count > mpe_pkg::MAX_POINTS_DEF) ? mpe_pkg::MAX_POINTS_DEF
                                                                     : point_count;
                        for (int i = 0; i < np; i++) begin
                            want.value = horner_value(points[i], nc);
                            want.index = i[5:0];
                            want.last  = (i + 1 == np);
                            pending_values.push_back(want);
                        end
                    end
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (pending_values.size() == 0) begin
                    report_mismatch("unexpected result", m_result_value, 64'd0);
                end else begin
                    want = pending_values.pop_front();
                    if (m_result_value !== want.value)
                        report_mismatch("result_value", m_result_value, want.value);
                    if (m_point_index !== want.index)
                        report_mismatch("point_index", {58'd0, m_point_index},
                                        {58'd0, want.index});
                    if (m_last_result !== want.last)
                        report_mismatch("last_result", {63'd0, m_last_result},
                                        {63'd0, want.last});
                end
            end
        end
        pending_count = pending_values.size();
    end

endmodule

### dv/tb.sv
// Testbench top for multipoint_poly_eval_mod_n: clock, reset, stimulus, receiver stalls,
// watchdog and verdict. Depends on mpe_pkg, mpe_checker and the block.
module tb;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 300000;
    localparam int SETTLE_CYCLES  = 150;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_action = '0;
    logic [63:0] s_operand_value = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_result_value;
    logic [5:0]  m_point_index;
    logic        m_last_result;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;

    int fail_count;
    int pending_count;
    int send_idle = 0;
    int recv_idle = 0;
    bit hold_req = 1'b0;
    int hold_left = 0;
    int stall_cycles = 0;
    int item_count = 0;
    int coef_wr = 0;
    int point_wr = 0;
    int coef_hw = 0;
    int point_hw = 0;

    multipoint_poly_eval_mod_n DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action),
        .s_operand_value(s_operand_value),
        .m_valid(m_valid), .m_ready(m_ready), .m_result_value(m_result_value),
        .m_point_index(m_point_index), .m_last_result(m_last_result),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    mpe_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action),
        .s_operand_value(s_operand_value),
        .m_valid(m_valid), .m_ready(m_ready), .m_result_value(m_result_value),
        .m_point_index(m_point_index), .m_last_result(m_last_result),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (hold_req) begin
            hold_left = 4000;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send(input logic [1:0] act, input logic [63:0] val);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_action        <= act;
        s_operand_value <= val;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        case (act)
            mpe_pkg::ACT_LOAD_COEF: begin
                if (coef_wr < mpe_pkg::MAX_COEFFS_DEF) coef_wr++;
                if (coef_wr > coef_hw) coef_hw = coef_wr;
            end
            mpe_pkg::ACT_LOAD_POINT: begin
                if (point_wr < mpe_pkg::MAX_POINTS_DEF) point_wr++;
                if (point_wr > point_hw) point_hw = point_wr;
            end
            mpe_pkg::ACT_START: begin
                coef_wr  = 0;
                point_wr = 0;
            end
            default: ;
        endcase
        if (act != ACT_UNUSED) item_count++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] rand_operand();
        case ($urandom_range(9))
            0:       return '1;
            1:       return '0;
            2:       return 64'($urandom_range(20));
            default: return rand64();
        endcase
    endfunction

    // Configure, load what the counts need plus extras (with some noise), then start.
    task automatic eval_run(input logic [63:0] modv, input int nc, input int np,
                            input int extra_c, input int extra_p);
        int nc_eff;
        int np_eff;
        int n_c;
        int n_p;
        drain();
        write_reg(mpe_pkg::REG_MODULUS, modv);
        write_reg(mpe_pkg::REG_COEF_COUNT, 64'(nc));
        write_reg(mpe_pkg::REG_POINT_COUNT, 64'(np));
        nc_eff = (nc > mpe_pkg::MAX_COEFFS_DEF) ? mpe_pkg::MAX_COEFFS_DEF : nc;
        np_eff = (np > mpe_pkg::MAX_POINTS_DEF) ? mpe_pkg::MAX_POINTS_DEF : np;
        n_c = ((nc_eff > coef_hw) ? nc_eff - coef_wr : 0) + extra_c;
        n_p = ((np_eff > point_hw) ? np_eff - point_wr : 0) + extra_p;
        while (n_c + n_p > 0) begin
            if ($urandom_range(19) == 0) send(ACT_UNUSED, rand64());
            if (n_p == 0 || (n_c > 0 && $urandom_range(n_c + n_p - 1) < n_c)) begin
                send(mpe_pkg::ACT_LOAD_COEF, rand_operand());
                n_c--;
            end else begin
                send(mpe_pkg::ACT_LOAD_POINT, rand_operand());
                n_p--;
            end
        end
        send(mpe_pkg::ACT_START, rand64());
    endtask

    function automatic logic [63:0] rand_modulus();
        logic [63:0] m;
        case ($urandom_range(11))
            0:       return 64'd0;
            1:       return '1;
            2:       return 64'd1;
            3:       return 64'd2;
            4, 5, 6: return 64'($urandom_range(1000, 3));
            default: begin
                m = rand64();
                return (m < 64'd2) ? 64'd7 : m;
            end
        endcase
    endfunction

    task automatic random_runs(input int target);
        int nc;
        int np;
        while (item_count < target) begin
            nc = ($urandom_range(9) == 0) ? $urandom_range(20, 7) : $urandom_range(6);
            np = ($urandom_range(9) == 0) ? 0 : $urandom_range(6, 1);
            if ($urandom_range(7) == 0)
                eval_run(rand_modulus(), nc, np, 0, 0);
            else
                eval_run(rand_modulus(), nc, np, $urandom_range(2), $urandom_range(2));
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle = 17;
        recv_idle = 77;
        eval_run(64'd0, 3, 2, 0, 0);
        eval_run('1, 3, 2, 0, 0);
        eval_run(64'd1, 2, 1, 0, 0);
        eval_run(64'd13, 0, 2, 0, 0);
        eval_run(64'd13, 1, 2, 0, 0);
        eval_run(64'd13, 2, 0, 0, 0);
        eval_run(64'd2, 4, 3, 1, 1);
        random_runs(60);

        send_idle = 77;
        recv_idle = 17;
        random_runs(130);

        send_idle = 0;
        recv_idle = 0;
        eval_run(rand_modulus(), 3, 6, 0, 0);
        hold_req = 1'b1;
        for (int i = 0; i < 12; i++) send(mpe_pkg::ACT_LOAD_COEF, rand64());
        eval_run(rand64() | 64'd2, 1, 127, 0, 1);
        random_runs(220);

        drain();
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### sim.f
rtl/mpe_pkg.sv
rtl/multipoint_poly_eval_mod_n.sv
dv/mpe_checker.sv
dv/tb.sv
